FILE: sv/fhce_pkg.sv
// Shared constants, types and ranking function for the frequency heap cache evictor.
`default_nettype none
package fhce_pkg;

  localparam int unsigned ItemIds   = 1024;
  localparam int unsigned HeapDepth = 256;
  localparam int unsigned ItemW     = 10;
  localparam int unsigned SlotW     = $clog2(HeapDepth);
  localparam int unsigned OccW      = $clog2(HeapDepth + 1);
  localparam int unsigned CntW      = 32;
  localparam int unsigned CapW      = 9;

  typedef struct packed {
    logic [ItemW-1:0] item;
    logic [CntW-1:0]  cnt;
    logic [CntW-1:0]  stamp;
  } heap_ent_t;

  typedef struct packed {
    logic             resident;
    logic [SlotW-1:0] slot;
  } item_ent_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    heap_ent_t        wdata;
    logic [SlotW-1:0] raddr;
  } heap_port_t;

  typedef struct packed {
    logic             we;
    logic [ItemW-1:0] waddr;
    item_ent_t        wdata;
    logic [ItemW-1:0] raddr;
  } item_port_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOOK, S_HIT, S_EVRD, S_EVLAST, S_DNREQ, S_DNC1, S_DNC2,
    S_DNCMP, S_DNFIN, S_INS, S_UPREQ, S_UPCMP, S_UPFIN, S_RUNCLR
  } state_e;

  // true if entry a ranks above entry b
  function automatic logic ranks_above(heap_ent_t a, heap_ent_t b);
    logic r;
    if (a.cnt != b.cnt) begin
      r = (a.cnt > b.cnt);
    end else begin
      r = (a.stamp < b.stamp);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/fhce_if.sv
// Request and response channel interfaces.
`default_nettype none
interface fhce_req_if;
  logic                         valid;
  logic                         ready;
  logic [fhce_pkg::ItemW-1:0]   requested_item;
  logic                         last_request;
  modport source (output valid, output requested_item, output last_request, input ready);
  modport sink (input valid, input requested_item, input last_request, output ready);
endinterface

interface fhce_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         evicted;
  logic [fhce_pkg::ItemW-1:0]   evicted_item;
  logic [fhce_pkg::CntW-1:0]    drop_count;
  modport source (output valid, output hit, output evicted, output evicted_item,
                  output drop_count, input ready);
  modport sink (input valid, input hit, input evicted, input evicted_item,
                input drop_count, output ready);
endinterface
`default_nettype wire

FILE: sv/fhce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fhce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: sv/fhce_ctrl.sv
// Sequencer: lookup, eviction, heap sift up and down, and run clearing.
`default_nettype none
module fhce_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [fhce_pkg::OccW-1:0]    cap_i,
  input  wire logic                         req_valid_i,
  output      logic                         req_ready_o,
  input  wire logic [fhce_pkg::ItemW-1:0]   req_item_i,
  input  wire logic                         req_last_i,
  output      logic                         rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output      logic                         rsp_hit_o,
  output      logic                         rsp_evicted_o,
  output      logic [fhce_pkg::ItemW-1:0]   rsp_evicted_item_o,
  output      logic [fhce_pkg::CntW-1:0]    rsp_drop_count_o,
  output      fhce_pkg::heap_port_t         hp_o,
  input  wire fhce_pkg::heap_ent_t          hp_rdata_i,
  output      fhce_pkg::item_port_t         ip_o,
  input  wire fhce_pkg::item_ent_t          ip_rdata_i
);
  localparam int unsigned SlotW = fhce_pkg::SlotW;
  localparam int unsigned OccW  = fhce_pkg::OccW;
  localparam int unsigned ItemW = fhce_pkg::ItemW;
  localparam int unsigned CntW  = fhce_pkg::CntW;

  fhce_pkg::state_e    state_q, state_d;
  logic [ItemW-1:0]    item_q, item_d;
  logic                last_q, last_d;
  fhce_pkg::heap_ent_t cur_q, cur_d, ch_q, ch_d;
  logic [SlotW-1:0]    pos_q, pos_d, chpos_q, chpos_d;
  logic [OccW-1:0]     occ_q, occ_d, k_q, k_d;
  logic [CntW-1:0]     ridx_q, ridx_d, drop_q, drop_d;
  logic                hit_q, hit_d, ev_q, ev_d, pend_q, pend_d;
  logic [ItemW-1:0]    vic_q, vic_d, clr_q, clr_d;
  logic                rv_q, rv_d, rh_q, rh_d, re_q, re_d;
  logic [ItemW-1:0]    rvic_q, rvic_d;
  logic [CntW-1:0]     rdrop_q, rdrop_d;
  logic [OccW-1:0]     c1, c2, occ_m1;

  assign c1     = {pos_q, 1'b1};
  assign c2     = {1'b0, chpos_q} + OccW'(1);
  assign occ_m1 = occ_q - OccW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fhce_pkg::S_CLR;
      occ_q   <= '0;
      ridx_q  <= '0;
      drop_q  <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      ridx_q  <= ridx_d;
      drop_q  <= drop_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    last_q  <= last_d;
    cur_q   <= cur_d;
    ch_q    <= ch_d;
    pos_q   <= pos_d;
    chpos_q <= chpos_d;
    hit_q   <= hit_d;
    ev_q    <= ev_d;
    vic_q   <= vic_d;
    rh_q    <= rh_d;
    re_q    <= re_d;
    rvic_q  <= rvic_d;
    rdrop_q <= rdrop_d;
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    last_d  = last_q;
    cur_d   = cur_q;
    ch_d    = ch_q;
    pos_d   = pos_q;
    chpos_d = chpos_q;
    occ_d   = occ_q;
    k_d     = k_q;
    ridx_d  = ridx_q;
    drop_d  = drop_q;
    hit_d   = hit_q;
    ev_d    = ev_q;
    vic_d   = vic_q;
    clr_d   = clr_q;
    pend_d  = pend_q;
    rv_d    = rv_q & ~rsp_ready_i;
    rh_d    = rh_q;
    re_d    = re_q;
    rvic_d  = rvic_q;
    rdrop_d = rdrop_q;
    hp_o    = '0;
    ip_o    = '0;
    req_ready_o = 1'b0;

    unique case (state_q)
      fhce_pkg::S_CLR: begin
        ip_o.we    = 1'b1;
        ip_o.waddr = clr_q;
        clr_d      = clr_q + ItemW'(1);
        if (clr_q == ItemW'(fhce_pkg::ItemIds - 1)) begin
          state_d = fhce_pkg::S_IDLE;
        end
      end
      fhce_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        ip_o.raddr  = req_item_i;
        if (req_valid_i) begin
          item_d  = req_item_i;
          last_d  = req_last_i;
          state_d = fhce_pkg::S_LOOK;
        end
      end
      fhce_pkg::S_LOOK: begin
        hit_d = ip_rdata_i.resident;
        ev_d  = 1'b0;
        vic_d = '0;
        if (ip_rdata_i.resident) begin
          hp_o.raddr = ip_rdata_i.slot;
          pos_d      = ip_rdata_i.slot;
          state_d    = fhce_pkg::S_HIT;
        end else if (occ_q >= cap_i) begin
          state_d = fhce_pkg::S_EVRD;
        end else begin
          state_d = fhce_pkg::S_INS;
        end
      end
      fhce_pkg::S_HIT: begin
        cur_d = hp_rdata_i;
        if (hp_rdata_i.cnt != '1) begin
          cur_d.cnt = hp_rdata_i.cnt + CntW'(1);
        end
        state_d = fhce_pkg::S_UPREQ;
      end
      fhce_pkg::S_EVRD: begin
        ev_d       = 1'b1;
        vic_d      = hp_rdata_i.item;
        ip_o.we    = 1'b1;
        ip_o.waddr = hp_rdata_i.item;
        occ_d      = occ_m1;
        if (drop_q != '1) begin
          drop_d = drop_q + CntW'(1);
        end
        if (occ_m1 != '0) begin
          hp_o.raddr = occ_m1[SlotW-1:0];
          state_d    = fhce_pkg::S_EVLAST;
        end else begin
          state_d = fhce_pkg::S_INS;
        end
      end
      fhce_pkg::S_EVLAST: begin
        cur_d   = hp_rdata_i;
        pos_d   = '0;
        state_d = fhce_pkg::S_DNREQ;
      end
      fhce_pkg::S_DNREQ: begin
        if (c1 >= occ_q) begin
          state_d = fhce_pkg::S_DNFIN;
        end else begin
          hp_o.raddr = c1[SlotW-1:0];
          chpos_d    = c1[SlotW-1:0];
          state_d    = fhce_pkg::S_DNC1;
        end
      end
      fhce_pkg::S_DNC1: begin
        ch_d = hp_rdata_i;
        if (c2 < occ_q) begin
          hp_o.raddr = c2[SlotW-1:0];
          state_d    = fhce_pkg::S_DNC2;
        end else begin
          state_d = fhce_pkg::S_DNCMP;
        end
      end
      fhce_pkg::S_DNC2: begin
        if (fhce_pkg::ranks_above(hp_rdata_i, ch_q)) begin
          ch_d    = hp_rdata_i;
          chpos_d = c2[SlotW-1:0];
        end
        state_d = fhce_pkg::S_DNCMP;
      end
      fhce_pkg::S_DNCMP: begin
        if (fhce_pkg::ranks_above(ch_q, cur_q)) begin
          // move the larger child up into the hole
          hp_o.we    = 1'b1;
          hp_o.waddr = pos_q;
          hp_o.wdata = ch_q;
          ip_o.we    = 1'b1;
          ip_o.waddr = ch_q.item;
          ip_o.wdata = '{resident: 1'b1, slot: pos_q};
          pos_d      = chpos_q;
          state_d    = fhce_pkg::S_DNREQ;
        end else begin
          state_d = fhce_pkg::S_DNFIN;
        end
      end
      fhce_pkg::S_DNFIN: begin
        hp_o.we    = 1'b1;
        hp_o.waddr = pos_q;
        hp_o.wdata = cur_q;
        ip_o.we    = 1'b1;
        ip_o.waddr = cur_q.item;
        ip_o.wdata = '{resident: 1'b1, slot: pos_q};
        state_d    = fhce_pkg::S_INS;
      end
      fhce_pkg::S_INS: begin
        cur_d   = '{item: item_q, cnt: CntW'(1), stamp: ridx_q};
        pos_d   = occ_q[SlotW-1:0];
        occ_d   = occ_q + OccW'(1);
        state_d = fhce_pkg::S_UPREQ;
      end
      fhce_pkg::S_UPREQ: begin
        if (pos_q == '0) begin
          state_d = fhce_pkg::S_UPFIN;
        end else begin
          hp_o.raddr = (pos_q - SlotW'(1)) >> 1;
          state_d    = fhce_pkg::S_UPCMP;
        end
      end
      fhce_pkg::S_UPCMP: begin
        if (fhce_pkg::ranks_above(cur_q, hp_rdata_i)) begin
          // pull the parent down into the hole
          hp_o.we    = 1'b1;
          hp_o.waddr = pos_q;
          hp_o.wdata = hp_rdata_i;
          ip_o.we    = 1'b1;
          ip_o.waddr = hp_rdata_i.item;
          ip_o.wdata = '{resident: 1'b1, slot: pos_q};
          pos_d      = (pos_q - SlotW'(1)) >> 1;
          state_d    = fhce_pkg::S_UPREQ;
        end else begin
          state_d = fhce_pkg::S_UPFIN;
        end
      end
      fhce_pkg::S_UPFIN: begin
        if (!rv_q || rsp_ready_i) begin
          hp_o.we    = 1'b1;
          hp_o.waddr = pos_q;
          hp_o.wdata = cur_q;
          ip_o.we    = 1'b1;
          ip_o.waddr = cur_q.item;
          ip_o.wdata = '{resident: 1'b1, slot: pos_q};
          rv_d       = 1'b1;
          rh_d       = hit_q;
          re_d       = ev_q;
          rvic_d     = vic_q;
          rdrop_d    = drop_q;
          if (ridx_q != '1) begin
            ridx_d = ridx_q + CntW'(1);
          end
          k_d    = '0;
          pend_d = 1'b0;
          state_d = last_q ? fhce_pkg::S_RUNCLR : fhce_pkg::S_IDLE;
        end
      end
      fhce_pkg::S_RUNCLR: begin
        // walk the live heap and drop residency of every entry
        if (pend_q) begin
          ip_o.we    = 1'b1;
          ip_o.waddr = hp_rdata_i.item;
        end
        if (k_q < occ_q) begin
          hp_o.raddr = k_q[SlotW-1:0];
          k_d        = k_q + OccW'(1);
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            occ_d   = '0;
            ridx_d  = '0;
            drop_d  = '0;
            state_d = fhce_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = fhce_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid_o        = rv_q;
  assign rsp_hit_o          = rh_q;
  assign rsp_evicted_o      = re_q;
  assign rsp_evicted_item_o = rvic_q;
  assign rsp_drop_count_o   = rdrop_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(fhce_pkg::HeapDepth))
    else $error("occupancy above heap depth");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rv_q) |-> $past(state_q == fhce_pkg::S_UPFIN))
    else $error("response raised outside final sift state");

  a_no_heap_write_in_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fhce_pkg::S_CLR || state_q == fhce_pkg::S_RUNCLR) |-> !hp_o.we)
    else $error("heap written during clearing");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fhce_pkg::S_EVRD |-> occ_q >= cap_i)
    else $error("eviction while not full");
endmodule
`default_nettype wire

FILE: sv/frequency_heap_cache_evictor_unit.sv
// Top level: capacity register, item and heap memories, and the sequencer.
// Most-frequently-used cache of up to capacity (1..256) items ranked on a binary
// max-heap kept in a 256-entry heap RAM, with a 1024-entry item RAM holding residency
// and heap slot. One request is handled at a time: a lookup, on a miss with a full
// cache an eviction of the root followed by a sift down, then a sift up; every heap
// level is read and compared in turn through the single read port of the heap RAM.
// After reset all 1024 item RAM entries are cleared before a request is taken; a
// request flagged last is followed by a sweep that empties the cache. A result may
// wait in the output register while the next request is accepted.
`default_nettype none
module frequency_heap_cache_evictor_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fhce_pkg::CapW-1:0]   cfg_wdata_i,
  fhce_req_if.sink                         req_i,
  fhce_rsp_if.source                       rsp_o
);
  logic [fhce_pkg::CapW-1:0] cap_q;
  logic [fhce_pkg::OccW-1:0] cap_eff;
  fhce_pkg::heap_port_t      hp;
  fhce_pkg::item_port_t      ip;
  fhce_pkg::heap_ent_t       hp_rdata;
  fhce_pkg::item_ent_t       ip_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= fhce_pkg::CapW'(fhce_pkg::HeapDepth);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // clamp capacity to 1..HeapDepth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = fhce_pkg::OccW'(1);
    end else if (cap_q > fhce_pkg::CapW'(fhce_pkg::HeapDepth)) begin
      cap_eff = fhce_pkg::OccW'(fhce_pkg::HeapDepth);
    end else begin
      cap_eff = fhce_pkg::OccW'(cap_q);
    end
  end

  fhce_ram #(
    .Width($bits(fhce_pkg::heap_ent_t)),
    .Depth(fhce_pkg::HeapDepth)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (hp.we),
    .waddr_i(hp.waddr),
    .wdata_i(hp.wdata),
    .raddr_i(hp.raddr),
    .rdata_o(hp_rdata)
  );

  fhce_ram #(
    .Width($bits(fhce_pkg::item_ent_t)),
    .Depth(fhce_pkg::ItemIds)
  ) u_item_ram (
    .clk_i  (clk_i),
    .we_i   (ip.we),
    .waddr_i(ip.waddr),
    .wdata_i(ip.wdata),
    .raddr_i(ip.raddr),
    .rdata_o(ip_rdata)
  );

  fhce_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cap_i             (cap_eff),
    .req_valid_i       (req_i.valid),
    .req_ready_o       (req_i.ready),
    .req_item_i        (req_i.requested_item),
    .req_last_i        (req_i.last_request),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_hit_o         (rsp_o.hit),
    .rsp_evicted_o     (rsp_o.evicted),
    .rsp_evicted_item_o(rsp_o.evicted_item),
    .rsp_drop_count_o  (rsp_o.drop_count),
    .hp_o              (hp),
    .hp_rdata_i        (hp_rdata),
    .ip_o              (ip),
    .ip_rdata_i        (ip_rdata)
  );
endmodule
`default_nettype wire
